@@ hw/rtl/sarq_pkg.sv @@
package sarq_pkg;

    localparam int SUM_BITS = 44;
    localparam int DIM_BITS = 7;

    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic [DIM_BITS-1:0] dim_t;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LD_ADD = 4'b0010,
        ST_LD_WR  = 4'b0100,
        ST_QUERY  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_RECT   = 2'd1,
        STATUS_NOT_LOADED = 2'd2
    } status_t;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    localparam logic [2:0] QUERY_LAST_STEP = 3'd4;

endpackage

@@ hw/rtl/sarq_table.sv @@
module sarq_table
    import sarq_pkg::*;
#(
    parameter int ADDR_BITS = 12
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  sum_t                 wdata,
    output sum_t                 rdata
);

    sum_t mem [2**ADDR_BITS];

    // Single port: a write cycle returns no read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ hw/rtl/summed_area_rectangle_query.sv @@
// Summed-area table with rectangle sum queries.
//
// Input channel: an item is taken at a rising edge with start high and busy
// low. req_type selects a load (cell_value is the next grid cell, row-major)
// or a query (row_top/col_left/row_bottom/col_right, 1-based, inclusive).
// A load makes no result; a query makes exactly one, shown on range_sum and
// status for one cycle with done high. The receiver cannot stall: a result
// is gone after that cycle.
// Config channel: cfg_index 0 writes grid_rows, 1 writes grid_cols; taken
// when cfg_valid and cfg_ready are high, only while idle with start low. A
// write clamps the value to 1..MAX, capped at 127, and restarts loading of the grid.
// Timing: a load passes through ST_LD_ADD and ST_LD_WR after the accept,
// one table read and one table write through the single-port table RAM,
// both sums on the one shared adder. A valid query holds busy through the
// query steps: four table reads, one per cycle, folded into the accumulator
// by the shared adder; done rises in the cycle after the last step. A query
// rejected for status (grid not loaded, bad corners) answers in the next
// cycle and never raises busy.
// Reset: loading restarts, grid size returns to 64 x 64 (clamped to MAX).
// The table RAM is not cleared; entries are written before they are read.
module summed_area_rectangle_query
    import sarq_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int CELL_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input items
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic signed [CELL_BITS-1:0] cell_value,
    input  logic [DIM_BITS-1:0]         row_top,
    input  logic [DIM_BITS-1:0]         col_left,
    input  logic [DIM_BITS-1:0]         row_bottom,
    input  logic [DIM_BITS-1:0]         col_right,
    // result items
    output logic                        done,
    output logic signed [SUM_BITS-1:0]  range_sum,
    output logic [1:0]                  status,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [DIM_BITS-1:0]         cfg_data
);

    localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int ROWS_CAP  = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COLS_CAP  = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int DIM_RESET = 64;
    localparam dim_t ROWS_RESET = (DIM_RESET > ROWS_CAP) ? dim_t'(ROWS_CAP) : dim_t'(DIM_RESET);
    localparam dim_t COLS_RESET = (DIM_RESET > COLS_CAP) ? dim_t'(COLS_CAP) : dim_t'(DIM_RESET);

    state_t state_reg, state_next;

    dim_t grid_rows_reg, grid_rows_next;
    dim_t grid_cols_reg, grid_cols_next;
    dim_t load_row_reg, load_row_next;
    dim_t load_col_reg, load_col_next;
    sum_t running_reg, running_next;
    logic loaded_reg, loaded_next;

    sum_t cell_reg, cell_next;
    dim_t r1_reg, r1_next;
    dim_t c1_reg, c1_next;
    dim_t r2_reg, r2_next;
    dim_t c2_reg, c2_next;
    logic [2:0] step_reg, step_next;
    sum_t acc_reg, acc_next;
    logic pend_zero_reg, pend_zero_next;
    logic pend_sub_reg, pend_sub_next;

    logic    done_reg, done_next;
    sum_t    sum_out_reg, sum_out_next;
    status_t status_reg, status_next;

    // shared adder
    sum_t alu_a;
    sum_t alu_b;
    logic alu_sub;
    sum_t alu_y;

    // table port
    logic                 tbl_we;
    logic [ADDR_BITS-1:0] tbl_addr;
    sum_t                 tbl_wdata;
    sum_t                 tbl_rdata;

    // query step decode
    dim_t q_row;
    dim_t q_col;
    logic q_zero;
    logic q_sub;

    logic       bad_rect;
    logic [7:0] col_inc;
    logic [7:0] row_inc;
    dim_t       cfg_clamped;

    sarq_table #(
        .ADDR_BITS (ADDR_BITS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign busy      = (state_reg != ST_IDLE);
    // an offered input item goes first; hold off the register write
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign done      = done_reg;
    assign range_sum = sum_out_reg;
    assign status    = status_reg;

    assign bad_rect = (row_top == '0) || (col_left == '0) || (row_top > row_bottom) ||
                      (col_left > col_right) || (row_bottom > grid_rows_reg) ||
                      (col_right > grid_cols_reg);

    assign col_inc = 8'(load_col_reg) + 8'd1;
    assign row_inc = 8'(load_row_reg) + 8'd1;

    // Corner for each query step: D(r2,c2) - B(r1-1,c2) - C(r2,c1-1) + A(r1-1,c1-1)
    always_comb
    begin
        q_row = r2_reg;
        q_col = c2_reg;
        q_sub = 1'b0;
        case (step_reg)
            3'd1:
            begin
                q_row = r1_reg - dim_t'(1);
                q_sub = 1'b1;
            end
            3'd2:
            begin
                q_col = c1_reg - dim_t'(1);
                q_sub = 1'b1;
            end
            3'd3:
            begin
                q_row = r1_reg - dim_t'(1);
                q_col = c1_reg - dim_t'(1);
            end
            default:
            begin
                q_row = r2_reg;
                q_col = c2_reg;
            end
        endcase
        q_zero = (q_row == '0) || (q_col == '0);
    end

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = dim_t'(1);
        end
        else if ((cfg_index == CFG_GRID_ROWS) && (cfg_data > dim_t'(ROWS_CAP)))
        begin
            cfg_clamped = dim_t'(ROWS_CAP);
        end
        else if ((cfg_index == CFG_GRID_COLS) && (cfg_data > dim_t'(COLS_CAP)))
        begin
            cfg_clamped = dim_t'(COLS_CAP);
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        running_next   = running_reg;
        loaded_next    = loaded_reg;
        cell_next      = cell_reg;
        r1_next        = r1_reg;
        c1_next        = c1_reg;
        r2_next        = r2_reg;
        c2_next        = c2_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        pend_zero_next = pend_zero_reg;
        pend_sub_next  = pend_sub_reg;
        done_next      = 1'b0;
        sum_out_next   = sum_out_reg;
        status_next    = status_reg;

        alu_a   = running_reg;
        alu_b   = cell_reg;
        alu_sub = 1'b0;

        tbl_we    = 1'b0;
        tbl_addr  = {ROW_BITS'(load_row_reg - dim_t'(1)), COL_BITS'(load_col_reg)};
        tbl_wdata = alu_y;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    // restart loading on any register write
                    if (cfg_index == CFG_GRID_ROWS)
                    begin
                        grid_rows_next = cfg_clamped;
                    end
                    else
                    begin
                        grid_cols_next = cfg_clamped;
                    end
                    load_row_next = '0;
                    load_col_next = '0;
                    running_next  = '0;
                    loaded_next   = 1'b0;
                end
                else if (start)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        // drop loads once the grid is complete
                        if (!loaded_reg)
                        begin
                            cell_next  = SUM_BITS'(cell_value);
                            state_next = ST_LD_ADD;
                        end
                    end
                    else if (!loaded_reg)
                    begin
                        done_next    = 1'b1;
                        sum_out_next = '0;
                        status_next  = STATUS_NOT_LOADED;
                    end
                    else if (bad_rect)
                    begin
                        done_next    = 1'b1;
                        sum_out_next = '0;
                        status_next  = STATUS_BAD_RECT;
                    end
                    else
                    begin
                        r1_next    = row_top;
                        c1_next    = col_left;
                        r2_next    = row_bottom;
                        c2_next    = col_right;
                        step_next  = '0;
                        acc_next   = '0;
                        state_next = ST_QUERY;
                    end
                end
            end

            ST_LD_ADD:
            begin
                // advance the row sum; fetch the entry above
                alu_a        = running_reg;
                alu_b        = cell_reg;
                running_next = alu_y;
                state_next   = ST_LD_WR;
            end

            ST_LD_WR:
            begin
                alu_a     = (load_row_reg == '0) ? '0 : tbl_rdata;
                alu_b     = running_reg;
                tbl_we    = 1'b1;
                tbl_addr  = {ROW_BITS'(load_row_reg), COL_BITS'(load_col_reg)};
                tbl_wdata = alu_y;
                if (col_inc >= 8'(grid_cols_reg))
                begin
                    load_col_next = '0;
                    running_next  = '0;
                    load_row_next = dim_t'(row_inc);
                    if (row_inc >= 8'(grid_rows_reg))
                    begin
                        loaded_next = 1'b1;
                    end
                end
                else
                begin
                    load_col_next = dim_t'(col_inc);
                end
                state_next = ST_IDLE;
            end

            ST_QUERY:
            begin
                tbl_addr = {ROW_BITS'(q_row - dim_t'(1)), COL_BITS'(q_col - dim_t'(1))};
                pend_zero_next = q_zero;
                pend_sub_next  = q_sub;
                // fold in the entry read on the previous step
                alu_a   = acc_reg;
                alu_b   = pend_zero_reg ? '0 : tbl_rdata;
                alu_sub = pend_sub_reg;
                if (step_reg != '0)
                begin
                    acc_next = alu_y;
                end
                if (step_reg == QUERY_LAST_STEP)
                begin
                    done_next    = 1'b1;
                    sum_out_next = alu_y;
                    status_next  = STATUS_OK;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grid_rows_reg <= ROWS_RESET;
            grid_cols_reg <= COLS_RESET;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            running_reg   <= '0;
            loaded_reg    <= 1'b0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            running_reg   <= running_next;
            loaded_reg    <= loaded_next;
            step_reg      <= step_next;
            done_reg      <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cell_reg      <= cell_next;
        r1_reg        <= r1_next;
        c1_reg        <= c1_next;
        r2_reg        <= r2_next;
        c2_reg        <= c2_next;
        acc_reg       <= acc_next;
        pend_zero_reg <= pend_zero_next;
        pend_sub_reg  <= pend_sub_next;
        sum_out_reg   <= sum_out_next;
        status_reg    <= status_next;
    end

endmodule
